// File: rtl/spp_pkg.sv
// Shared widths, reset values, register indexes and control types for the
// stepper position step pacer. No dependencies; every other file imports it.
package spp_pkg;

   // Field and register widths.
   localparam int POS_W     = 12;  // encoder and target angle, signed
   localparam int TIME_W    = 32;  // microsecond timestamp
   localparam int CFG_W     = 12;  // narrow configuration registers
   localparam int WIDE_W    = 16;  // speed and unwind registers, csr data
   localparam int CSR_IDX_W = 3;
   localparam int ERR_W     = 13;  // reported position error
   localparam int PERIOD_W  = 20;  // pulse period in microseconds
   localparam int TURN_W    = 16;  // saturating turn counter

   // Derived datapath widths.
   localparam int RAW_W   = POS_W + 1;
   localparam int WRAP_W  = ((RAW_W > CFG_W) ? RAW_W : CFG_W) + 1;
   localparam int MAG_W   = WRAP_W - 1;
   localparam int SPEED_W = WIDE_W + MAG_W;
   localparam int DIV_N   = PERIOD_W;
   localparam int DIV_CNT_W = $clog2(DIV_N);
   localparam int CMP_W   = (TIME_W > PERIOD_W) ? TIME_W : PERIOD_W;

   localparam int FLIP_LIMIT     = 90;
   localparam int MICROS_PER_SEC = 1000000;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0]  HALF_TURN_RESET  = CFG_W'(100);
   localparam logic [CFG_W-1:0]  FULL_TURN_RESET  = CFG_W'(200);
   localparam logic [CFG_W-1:0]  MAX_ERR_RESET    = CFG_W'(10);
   localparam logic [CFG_W-1:0]  SLOW_ZONE_RESET  = CFG_W'(20);
   localparam logic [WIDE_W-1:0] TOP_SPEED_RESET  = WIDE_W'(1000);
   localparam logic [WIDE_W-1:0] BOT_SPEED_RESET  = WIDE_W'(100);
   localparam logic [WIDE_W-1:0] UNWIND_RESET     = WIDE_W'(200);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_TURN = 3'd0,
      CSR_FULL_TURN = 3'd1,
      CSR_MAX_ERR   = 3'd2,
      CSR_SLOW_ZONE = 3'd3,
      CSR_TOP_SPEED = 3'd4,
      CSR_BOT_SPEED = 3'd5,
      CSR_UNWIND    = 3'd6
   } csr_index_type;

   localparam logic REQ_POSITION = 1'b0;
   localparam logic REQ_UNWIND   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SELECT,
      ST_QUOT_WAIT,
      ST_SCALE,
      ST_PERIOD_START,
      ST_PERIOD_WAIT,
      ST_FINISH
   } spp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // register the request fields
      logic wrap;         // wrapped error and turn counting
      logic select_fast;  // speed is top speed
      logic div_quot;     // start top speed / slow zone
      logic scale;        // speed from quotient times error magnitude
      logic div_period;   // start one million / speed
      logic finish;       // update state and load the result register
   } spp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_unwind;
      logic fast_path;
      logic div_done;
      logic out_free;
   } spp_stat_type;

endpackage

// File: rtl/spp_if.sv
// Valid/ready channel interfaces for requests and results of the step pacer.
// Depends on spp_pkg for field widths.
interface spp_req_if;
   import spp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic signed [POS_W-1:0]  encoder_pos;
   logic signed [POS_W-1:0]  target_pos;
   logic [TIME_W-1:0]        now_us;

   modport source (output valid, req_type, encoder_pos, target_pos, now_us, input ready);
   modport sink   (input valid, req_type, encoder_pos, target_pos, now_us, output ready);
endinterface

interface spp_rsp_if;
   import spp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     step_pulse;
   logic                     direction;
   logic                     angle_error_flag;
   logic signed [TURN_W-1:0] turn_count;
   logic signed [ERR_W-1:0]  position_error;
   logic [PERIOD_W-1:0]      pulse_period_us;

   modport source (output valid, step_pulse, direction, angle_error_flag, turn_count,
                   position_error, pulse_period_us, input ready);
   modport sink   (input valid, step_pulse, direction, angle_error_flag, turn_count,
                   position_error, pulse_period_us, output ready);
endinterface

// File: rtl/stepper_position_step_pacer.sv
// Top level of the stepper position step pacer: joins the request and result
// channels and the register port to the controller and the datapath.
// Depends on spp_pkg, spp_if, spp_ctrl, spp_dp and spp_div.
//
//   Channel   Direction  Handshake        Contents
//   req_chan  in         valid / ready    req_type, encoder_pos, target_pos, now_us
//   rsp_chan  out        valid / ready    pulse, direction, error flag, turns, error, period
//   csr_*     in         csr_we only      register index and write data
//
// A position command at the top speed runs the shared one-bit-per-cycle divider
// once, for the period; inside the slow zone it first divides top speed by the
// zone width. An unwind request skips the divider. Each division runs 20 steps.
// Reset is synchronous and active high; it loads the register defaults and clears
// the turn counter, the pulse timestamp and the direction. A new request is taken while a
// finished result is still held; a stalled result only holds up retirement.
module stepper_position_step_pacer (
   input  logic                          clock,
   input  logic                          reset,
   spp_req_if.sink                       req_chan,
   spp_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [spp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spp_pkg::WIDE_W-1:0]    csr_wdata
);
   import spp_pkg::*;

   spp_cmd_type  cmd;
   spp_stat_type stat;

   // The controller owns request acceptance and the order of datapath steps.
   spp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds all arithmetic, the state and the result register,
   // which lets the result transfer proceed independently of new requests.
   spp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_chan.req_type),
      .encoder_pos      (req_chan.encoder_pos),
      .target_pos       (req_chan.target_pos),
      .now_us           (req_chan.now_us),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .step_pulse       (rsp_chan.step_pulse),
      .direction        (rsp_chan.direction),
      .angle_error_flag (rsp_chan.angle_error_flag),
      .turn_count       (rsp_chan.turn_count),
      .position_error   (rsp_chan.position_error),
      .pulse_period_us  (rsp_chan.pulse_period_us)
   );

endmodule

// File: rtl/spp_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by the speed
// and period computations. Depends on spp_pkg.
module spp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [spp_pkg::DIV_N-1:0]   dividend,
   input  logic [spp_pkg::SPEED_W-1:0] divisor,
   output logic [spp_pkg::DIV_N-1:0]   quotient,
   output logic                        done
);
   import spp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N-1:0]     quot_ff, quot_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0]   dsr_ff, dsr_in;

   logic [SPEED_W:0] shifted;
   logic [SPEED_W:0] diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_N-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N - 1);
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_N-2:0], ge};
         rem_in  = ge ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

   // A new division is only started once the previous one has finished.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// File: rtl/spp_ctrl.sv
// Sequencing state machine of the step pacer: steps one request through the
// datapath. Depends on spp_pkg.
module spp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spp_pkg::spp_stat_type stat,
   output spp_pkg::spp_cmd_type  cmd
);
   import spp_pkg::*;

   spp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = stat.is_unwind ? ST_FINISH : ST_SELECT;
         end
         ST_SELECT: begin
            if (stat.fast_path) begin
               cmd.select_fast = 1'b1;
               state_in        = ST_PERIOD_START;
            end else begin
               cmd.div_quot = 1'b1;
               state_in     = ST_QUOT_WAIT;
            end
         end
         ST_QUOT_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_PERIOD_START;
         end
         ST_PERIOD_START: begin
            cmd.div_period = 1'b1;
            state_in       = ST_PERIOD_WAIT;
         end
         ST_PERIOD_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/spp_dp.sv
// Datapath of the step pacer: configuration registers, error wrapping, turn
// counting, speed and period, pulse timing and the result register.
// Depends on spp_pkg and instantiates spp_div.
module spp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  spp_pkg::spp_cmd_type              cmd,
   output spp_pkg::spp_stat_type             stat,
   input  logic                              csr_we,
   input  logic [spp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spp_pkg::WIDE_W-1:0]        csr_wdata,
   input  logic                              req_type,
   input  logic signed [spp_pkg::POS_W-1:0]  encoder_pos,
   input  logic signed [spp_pkg::POS_W-1:0]  target_pos,
   input  logic [spp_pkg::TIME_W-1:0]        now_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              step_pulse,
   output logic                              direction,
   output logic                              angle_error_flag,
   output logic signed [spp_pkg::TURN_W-1:0] turn_count,
   output logic signed [spp_pkg::ERR_W-1:0]  position_error,
   output logic [spp_pkg::PERIOD_W-1:0]      pulse_period_us
);
   import spp_pkg::*;

   localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
   localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

   // Configuration registers.
   logic [CFG_W-1:0]  half_ff, full_ff, maxerr_ff, slow_ff;
   logic [WIDE_W-1:0] top_ff, bot_ff, unwind_ff;

   // Persistent state.
   logic [TIME_W-1:0]        last_ff, last_in;
   logic signed [POS_W-1:0]  prev_ff, prev_in;
   logic signed [TURN_W-1:0] turn_ff, turn_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic                     dir_ff, dir_in;
   logic                     flag_ff, flag_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   logic                     kind_ff;
   logic signed [POS_W-1:0]  pos_ff, tgt_ff;
   logic [TIME_W-1:0]        now_ff;
   logic signed [WRAP_W-1:0] err_ff;
   logic [SPEED_W-1:0]       speed_ff;

   // Result register.
   logic                     pulse_out_ff, dir_out_ff, flag_out_ff;
   logic signed [TURN_W-1:0] turn_out_ff;
   logic signed [ERR_W-1:0]  err_out_ff;
   logic [PERIOD_W-1:0]      period_out_ff;

   // Divider.
   logic                div_start, div_done;
   logic [DIV_N-1:0]    div_dividend, div_quotient;
   logic [SPEED_W-1:0]  div_divisor;

   // Combinational values.
   logic signed [WRAP_W-1:0] raw_err, wrap_err, full_ext;
   logic [WRAP_W-1:0]        raw_abs, err_abs;
   logic [MAG_W-1:0]         raw_mag, err_mag;
   logic [POS_W-1:0]         pos_abs;
   logic                     pos_neg, prev_neg, flip_ok;
   logic [SPEED_W-1:0]       scaled;
   logic [PERIOD_W-1:0]      period_new, period_used;
   logic [TIME_W-1:0]        elapsed;
   logic                     due, pulse, dir_new, flag_new;

   spp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      // Error wrapping to the shorter way round.
      raw_err = {{(WRAP_W-POS_W){tgt_ff[POS_W-1]}}, tgt_ff}
              - {{(WRAP_W-POS_W){pos_ff[POS_W-1]}}, pos_ff};
      raw_abs = raw_err[WRAP_W-1] ? -raw_err : raw_err;
      raw_mag = raw_abs[MAG_W-1:0];
      full_ext = {{(WRAP_W-CFG_W){1'b0}}, full_ff};
      wrap_err = raw_err;
      if ({{(MAG_W-CFG_W){1'b0}}, half_ff} < raw_mag) begin
         wrap_err = raw_err[WRAP_W-1] ? (raw_err + full_ext) : (raw_err - full_ext);
      end

      err_abs = err_ff[WRAP_W-1] ? -err_ff : err_ff;
      err_mag = err_abs[MAG_W-1:0];

      // Turn counting on a sign change of a reading beyond the flip limit.
      pos_neg  = pos_ff[POS_W-1];
      prev_neg = prev_ff[POS_W-1];
      pos_abs  = pos_neg ? -pos_ff : pos_ff;
      flip_ok  = (pos_abs > POS_W'(FLIP_LIMIT)) && (prev_ff != '0);

      // Speed in the slow zone.
      scaled = div_quotient[WIDE_W-1:0] * err_mag;

      div_start    = cmd.div_quot | cmd.div_period;
      div_dividend = cmd.div_quot ? {{(DIV_N-WIDE_W){1'b0}}, top_ff}
                                  : DIV_N'(MICROS_PER_SEC);
      div_divisor  = cmd.div_quot ? {{(SPEED_W-CFG_W){1'b0}}, slow_ff} : speed_ff;

      // Final decisions.
      period_new  = (speed_ff == '0) ? PERIOD_W'(MICROS_PER_SEC) : div_quotient;
      period_used = kind_ff ? period_ff : period_new;
      elapsed     = now_ff - last_ff;
      due         = (CMP_W'(elapsed) >= CMP_W'(period_used));
      if (kind_ff == REQ_UNWIND) begin
         pulse    = (turn_ff != '0) && (unwind_ff != '0) && due;
         dir_new  = (turn_ff != '0) ? turn_ff[TURN_W-1] : dir_ff;
         flag_new = flag_ff;
      end else begin
         pulse    = (err_ff != '0) && due;
         dir_new  = (err_ff != '0) ? !err_ff[WRAP_W-1] : dir_ff;
         flag_new = (err_mag > {{(MAG_W-CFG_W){1'b0}}, maxerr_ff});
      end

      stat.is_unwind = (kind_ff == REQ_UNWIND);
      stat.fast_path = (err_mag > {{(MAG_W-CFG_W){1'b0}}, slow_ff}) || (err_mag == '0)
                       || (slow_ff == '0);
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || rsp_ready;

      // State updates.
      prev_in = prev_ff;
      turn_in = turn_ff;
      if (cmd.wrap) begin
         prev_in = pos_ff;
         if (flip_ok && !pos_neg && prev_neg && (turn_ff != TURN_MIN)) begin
            turn_in = turn_ff - 1'b1;
         end else if (flip_ok && pos_neg && !prev_neg && (turn_ff != TURN_MAX)) begin
            turn_in = turn_ff + 1'b1;
         end
      end

      last_in   = last_ff;
      period_in = period_ff;
      dir_in    = dir_ff;
      flag_in   = flag_ff;
      if (cmd.finish) begin
         period_in = period_used;
         dir_in    = dir_new;
         flag_in   = flag_new;
         if (pulse) begin
            last_in = now_ff;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= HALF_TURN_RESET;
         full_ff      <= FULL_TURN_RESET;
         maxerr_ff    <= MAX_ERR_RESET;
         slow_ff      <= SLOW_ZONE_RESET;
         top_ff       <= TOP_SPEED_RESET;
         bot_ff       <= BOT_SPEED_RESET;
         unwind_ff    <= UNWIND_RESET;
         last_ff      <= '0;
         prev_ff      <= '0;
         turn_ff      <= '0;
         period_ff    <= '0;
         dir_ff       <= 1'b0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_HALF_TURN: half_ff   <= csr_wdata[CFG_W-1:0];
               CSR_FULL_TURN: full_ff   <= csr_wdata[CFG_W-1:0];
               CSR_MAX_ERR:   maxerr_ff <= csr_wdata[CFG_W-1:0];
               CSR_SLOW_ZONE: slow_ff   <= csr_wdata[CFG_W-1:0];
               CSR_TOP_SPEED: top_ff    <= csr_wdata;
               CSR_BOT_SPEED: bot_ff    <= csr_wdata;
               CSR_UNWIND:    unwind_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         turn_ff      <= turn_in;
         period_ff    <= period_in;
         dir_ff       <= dir_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_type;
         pos_ff  <= encoder_pos;
         tgt_ff  <= target_pos;
         now_ff  <= now_us;
      end
      if (cmd.wrap) begin
         err_ff <= (kind_ff == REQ_UNWIND) ? '0 : wrap_err;
      end
      if (cmd.select_fast) begin
         speed_ff <= {{(SPEED_W-WIDE_W){1'b0}}, top_ff};
      end else if (cmd.scale) begin
         speed_ff <= (scaled < {{(SPEED_W-WIDE_W){1'b0}}, bot_ff})
                     ? {{(SPEED_W-WIDE_W){1'b0}}, bot_ff} : scaled;
      end
      if (cmd.finish) begin
         pulse_out_ff  <= pulse;
         dir_out_ff    <= dir_new;
         flag_out_ff   <= flag_new;
         turn_out_ff   <= turn_ff;
         err_out_ff    <= err_ff[ERR_W-1:0];
         period_out_ff <= period_used;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign step_pulse       = pulse_out_ff;
   assign direction        = dir_out_ff;
   assign angle_error_flag = flag_out_ff;
   assign turn_count       = turn_out_ff;
   assign position_error   = err_out_ff;
   assign pulse_period_us  = period_out_ff;

   // A result is never loaded over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // The turn counter moves by at most one turn per request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((turn_ff == $past(turn_ff)) || (turn_ff == $past(turn_ff) + 1'b1)
                         || (turn_ff == $past(turn_ff) - 1'b1)))
      else $error("turn counter jumped");

   // The pulse timestamp only changes when a request is retired.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (last_ff != $past(last_ff))) |-> $past(cmd.finish))
      else $error("pulse timestamp changed outside of retirement");

endmodule
